FILE: hdl/anbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_pkg
// Types and constants shared by the Annex B NAL unit splitter modules.
// ----------------------------------------------------------------------------
package anbs_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TYPE_W     = 5;
    localparam int unsigned WIN_DEPTH  = 4;   // bytes held back
    localparam int unsigned BUNDLE_MAX = 5;   // most bytes released by one input byte
    localparam int unsigned CNT_W      = 3;   // holds 0 .. BUNDLE_MAX
    localparam int unsigned QDEPTH     = 4;   // bundle queue entries
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned QCNT_W     = 3;

    localparam logic [TYPE_W-1:0] TYPE_MASK         = 5'h1F;
    localparam logic [TYPE_W-1:0] DEFAULT_DROP_TYPE = 5'h09;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DROP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_DROP_TYPE   = 2'd1;

    // All the bytes that one input byte releases, as a prefix of the window.
    typedef struct packed {
        logic [BUNDLE_MAX-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                  count;
        logic [TYPE_W-1:0]                 utype;
        logic                              first;  // bytes[0] is a unit header
        logic                              last;   // final byte closes the unit
    } bundle_t;

    // Queue handshake as seen from the producer or the consumer side.
    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } queue_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/anbs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_front
// Holdback window, start code detection and unit classification. Each
// accepted byte produces at most one bundle of released bytes.
// ----------------------------------------------------------------------------
module anbs_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [anbs_pkg::TYPE_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [anbs_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                          in_eos,
    input  wire logic                          q_full,
    output logic                               q_push,
    output anbs_pkg::bundle_t                  q_data
);

    logic [anbs_pkg::BYTE_W-1:0] hold_reg [anbs_pkg::WIN_DEPTH];
    logic [anbs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        inside_reg, inside_next;
    logic                        exph_reg, exph_next;
    logic                        drop_reg, drop_next;
    logic [anbs_pkg::TYPE_W-1:0] ctype_reg, ctype_next;
    logic                        hp_reg, hp_next;
    logic                        den_reg;
    logic [anbs_pkg::TYPE_W-1:0] dtype_reg;

    logic [anbs_pkg::BYTE_W-1:0] win [anbs_pkg::BUNDLE_MAX];
    logic                        accept;
    logic                        sc;
    logic                        len4;
    logic [anbs_pkg::CNT_W-1:0]  n_cnt;
    logic [anbs_pkg::CNT_W-1:0]  pre;
    logic [anbs_pkg::CNT_W-1:0]  m_cnt;
    logic                        b_zero, b_one;
    logic [anbs_pkg::TYPE_W-1:0] type_now;
    logic                        drop_now;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b_zero   = (in_byte == '0);
    assign b_one    = (in_byte == anbs_pkg::BYTE_W'(1));
    assign n_cnt    = anbs_pkg::CNT_W'(count_reg + 1'b1);

    // Type and drop decision of the unit that the released bytes belong to.
    assign type_now = exph_reg ? (in_byte[anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK)
                               : ctype_reg;
    assign drop_now = exph_reg ? (den_reg && (type_now == dtype_reg)) : drop_reg;

    // Window as the model sees it: held bytes followed by the new byte.
    always_comb
    begin
        for (int i = 0; i < anbs_pkg::WIN_DEPTH; i++)
        begin
            win[i] = (anbs_pkg::CNT_W'(i) < count_reg) ? hold_reg[i] : in_byte;
        end
        win[anbs_pkg::WIN_DEPTH] = in_byte;
    end

    // Start code at the end of the window, fixed compares per fill level.
    always_comb
    begin
        sc   = 1'b0;
        len4 = 1'b0;
        case (count_reg)
            3'd2:
            begin
                sc = (hold_reg[0] == '0) && (hold_reg[1] == '0) && b_one;
            end
            3'd3:
            begin
                sc   = (hold_reg[1] == '0) && (hold_reg[2] == '0) && b_one;
                len4 = (hold_reg[0] == '0);
            end
            3'd4:
            begin
                sc   = (hold_reg[2] == '0) && (hold_reg[3] == '0) && b_one;
                len4 = (hold_reg[1] == '0);
            end
            default:
            begin
                sc   = 1'b0;
                len4 = 1'b0;
            end
        endcase
    end

    assign pre = n_cnt - (len4 ? 3'd4 : 3'd3);

    // Released bytes are always a prefix of the window.
    always_comb
    begin
        if (sc)
            m_cnt = pre;
        else if (in_eos)
            m_cnt = n_cnt;
        else if (count_reg == anbs_pkg::CNT_W'(anbs_pkg::WIN_DEPTH))
            m_cnt = 3'd1;
        else
            m_cnt = '0;
    end

    always_comb
    begin
        if (exph_reg)
        begin
            ctype_next = in_byte[anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK;
            drop_next  = den_reg && (ctype_next == dtype_reg);
        end
        else
        begin
            ctype_next = ctype_reg;
            drop_next  = drop_reg;
        end
        exph_next   = 1'b0;
        inside_next = inside_reg;
        hp_next     = (m_cnt != '0) ? 1'b0 : hp_reg;
        count_next  = n_cnt;
        if (in_eos)
        begin
            count_next  = '0;
            inside_next = 1'b0;
            exph_next   = 1'b0;
            drop_next   = 1'b0;
            ctype_next  = '0;
            hp_next     = 1'b0;
        end
        else if (sc)
        begin
            count_next  = '0;
            inside_next = 1'b1;
            exph_next   = 1'b1;
            hp_next     = 1'b1;
            drop_next   = 1'b0;
        end
        else if (count_reg == anbs_pkg::CNT_W'(anbs_pkg::WIN_DEPTH))
        begin
            count_next = anbs_pkg::CNT_W'(anbs_pkg::WIN_DEPTH);
        end
    end

    always_comb
    begin
        for (int i = 0; i < anbs_pkg::BUNDLE_MAX; i++)
        begin
            q_data.bytes[i] = win[i];
        end
        q_data.count = m_cnt;
        q_data.utype = exph_reg ? (in_byte[anbs_pkg::TYPE_W-1:0] & anbs_pkg::TYPE_MASK)
                                : ctype_reg;
        q_data.first = hp_reg;
        q_data.last  = sc || in_eos;
    end

    // Bytes of a dropped unit, or bytes before the first start code, vanish here.
    assign q_push = accept && inside_reg && !drop_now && (m_cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            inside_reg <= 1'b0;
            exph_reg   <= 1'b0;
            drop_reg   <= 1'b0;
            ctype_reg  <= '0;
            hp_reg     <= 1'b0;
            den_reg    <= 1'b1;
            dtype_reg  <= anbs_pkg::DEFAULT_DROP_TYPE;
        end
        else
        begin
            if (accept)
            begin
                count_reg  <= count_next;
                inside_reg <= inside_next;
                exph_reg   <= exph_next;
                drop_reg   <= drop_next;
                ctype_reg  <= ctype_next;
                hp_reg     <= hp_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    anbs_pkg::CFG_DROP_ENABLE: den_reg   <= cfg_data[0];
                    anbs_pkg::CFG_DROP_TYPE:   dtype_reg <= cfg_data;
                    default:                   den_reg   <= den_reg;
                endcase
            end
        end
    end

    // Window contents; a full window shifts out its oldest byte.
    always_ff @(posedge clk)
    begin
        if (accept && !sc && !in_eos)
        begin
            if (count_reg == anbs_pkg::CNT_W'(anbs_pkg::WIN_DEPTH))
            begin
                for (int i = 0; i < anbs_pkg::WIN_DEPTH; i++)
                begin
                    hold_reg[i] <= win[i+1];
                end
            end
            else
            begin
                hold_reg[count_reg[1:0]] <= in_byte;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/anbs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_queue
// Short queue of bundles between the classifying front and the output back.
// ----------------------------------------------------------------------------
module anbs_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire anbs_pkg::bundle_t push_data,
    input  wire logic          pop,
    output anbs_pkg::queue_ctl_t status,
    output anbs_pkg::bundle_t  head
);

    anbs_pkg::bundle_t              mem [anbs_pkg::QDEPTH];
    logic [anbs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [anbs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [anbs_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign status.full  = (cnt_reg == anbs_pkg::QCNT_W'(anbs_pkg::QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign status.push  = do_push;
    assign status.pop   = do_pop;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: hdl/anbs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_back
// Walks the head bundle one byte per cycle into the output register if ready.
// ----------------------------------------------------------------------------
module anbs_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire anbs_pkg::bundle_t             head,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [anbs_pkg::BYTE_W-1:0]        out_byte,
    output logic [anbs_pkg::TYPE_W-1:0]        out_type,
    output logic                               out_first,
    output logic                               out_last
);

    logic [anbs_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [anbs_pkg::BYTE_W-1:0] byte_reg;
    logic [anbs_pkg::TYPE_W-1:0] type_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic                        load;
    logic                        at_end;

    assign load   = !q_empty && (!valid_reg || out_ready);
    assign at_end = (idx_reg == anbs_pkg::CNT_W'(head.count - 1'b1));
    assign q_pop  = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= head.bytes[idx_reg];
            type_reg  <= head.utype;
            first_reg <= head.first && (idx_reg == '0);
            last_reg  <= head.last && at_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_type  = type_reg;
    assign out_first = first_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

FILE: hdl/annexb_nal_unit_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex B byte stream into NAL unit bytes, start codes removed.
// ----------------------------------------------------------------------------
//  channel   direction  word                                   end mark
//  s_axis    in         tdata = stream byte                    tlast = end of stream
//  m_axis    out        tdata = NAL byte, tuser = type, first  tlast = last of unit
//  cfg       in         cfg_index selects register, cfg_data   none
//
// One stream byte is taken per cycle. A byte releases up to five output words
// (a flush at end of stream); the back end sends one word per cycle while the
// output is ready, and the input waits only while the four-bundle queue is full.
// Words pass the bundle queue, then the output register. Reset clears all stream
// state and loads drop_enable = 1, drop_type = 9. The cfg channel is always ready.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] nal_byte
    output logic [5:0]       m_axis_tuser,   // [4:0] unit_type, [5] first_of_unit
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    anbs_pkg::bundle_t    push_data;
    anbs_pkg::bundle_t    head;
    anbs_pkg::queue_ctl_t q_status;
    logic                 push;
    logic                 pop;
    logic [4:0]           out_type;
    logic                 out_first;

    assign cfg_ready = 1'b1;

    anbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_eos    (s_axis_tlast),
        .q_full    (q_status.full),
        .q_push    (push),
        .q_data    (push_data)
    );

    anbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    anbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_status.empty),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_type  (out_type),
        .out_first (out_first),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = {out_first, out_type};

endmodule
`default_nettype wire

FILE: hdl/anbs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_checker
// Port-level checks of unit framing on the output of the splitter.
// ----------------------------------------------------------------------------
module anbs_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic [5:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    logic       out_acc;
    logic       prev_last_reg;
    logic [4:0] prev_type_reg;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Marks of the previous word sent, to check unit boundaries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_last_reg <= 1'b1;
            prev_type_reg <= '0;
        end
        else if (out_acc)
        begin
            prev_last_reg <= m_axis_tlast;
            prev_type_reg <= m_axis_tuser[4:0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_axis_tuser[5] |-> prev_last_reg)
        else $error("unit header sent inside an open unit");

    a_last_then_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && prev_last_reg |-> m_axis_tuser[5])
        else $error("unit started without a header mark");

    a_type_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !prev_last_reg |-> m_axis_tuser[4:0] == prev_type_reg)
        else $error("unit type changed inside a unit");

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (.*);
`default_nettype wire
